// ===== hw/rtl/dcft_pkg.sv =====
package dcft_pkg;

	localparam int TW = 48;
	localparam int DW = 40;
	localparam logic signed [DW-1:0] S40_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] S40_MIN = {1'b1, {(DW-1){1'b0}}};

	localparam logic [1:0] ST_ARMED    = 2'd0;
	localparam logic [1:0] ST_DISABLED = 2'd1;
	localparam logic [1:0] ST_NO_OUT   = 2'd2;

	localparam logic [2:0] CFG_DISABLED = 3'd0;
	localparam logic [2:0] CFG_PRIMARY  = 3'd1;
	localparam logic [2:0] CFG_FORMAT   = 3'd2;
	localparam logic [2:0] CFG_FRAME    = 3'd3;
	localparam logic [2:0] CFG_RATE     = 3'd4;
	localparam logic [2:0] CFG_IRATE    = 3'd5;
	localparam logic [2:0] CFG_MAXCORR  = 3'd6;
	localparam logic [2:0] CFG_START    = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DRIFT,
		S_ADJ,
		S_MUL,
		S_DIV,
		S_TS,
		S_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic drift;
		logic adj;
		logic mul_start;
		logic div_start;
		logic frame;
		logic ts;
		logic skip;
		logic set_sat;
	} cmd_t;

	typedef struct packed {
		logic bypass;
		logic fmt;
		logic mul_done;
		logic div_done;
		logic past;
		logic limit;
	} sts_t;

	function automatic logic signed [DW-1:0] sat40(input logic signed [DW:0] v);
		logic signed [DW-1:0] r;
		r = v[DW-1:0];
		if (v > $signed({S40_MAX[DW-1], S40_MAX})) r = S40_MAX;
		else if (v < $signed({S40_MIN[DW-1], S40_MIN})) r = S40_MIN;
		return r;
	endfunction

endpackage

// ===== hw/rtl/dcft_ctrl.sv =====
module dcft_ctrl
	import dcft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.bypass ? S_DONE : S_DRIFT;
				end
			end
			S_DRIFT: begin
				cmd.drift = 1'b1;
				state_d   = S_ADJ;
			end
			S_ADJ: begin
				cmd.adj = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				// one frame step: nominal advance or rate based quotient
				if (!sts.fmt) begin
					cmd.frame = 1'b1;
					state_d   = S_TS;
				end else begin
					cmd.mul_start = 1'b1;
					if (sts.mul_done) state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				if (sts.div_done) begin
					cmd.frame = 1'b1;
					state_d   = S_TS;
				end
			end
			S_TS: begin
				cmd.ts  = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (!sts.past) state_d = S_DONE;
				else if (sts.limit) begin
					cmd.set_sat = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.skip = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/dcft_dp.sv =====
module dcft_dp
	import dcft_pkg::*;
#(
	parameter int MAX_CATCHUP_FRAMES = 64,
	parameter int SKW = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  timer_disabled,
	input  logic                  primary_output_present,
	input  logic                  format_set,
	input  logic [16:0]           frame_duration_us,
	input  logic [18:0]           sample_rate_hz,
	input  logic [35:0]           integer_rate_us,
	input  logic [9:0]            max_correction_us,
	input  logic [TW-1:0]         start_time_us,
	input  logic [TW-1:0]         current_time_us,
	input  logic                  peer_connected,
	input  logic signed [31:0]    peer_drift_us,
	output logic [1:0]            status,
	output logic [TW-1:0]         next_timestamp_us,
	output logic signed [DW-1:0]  corrected_drift_us,
	output logic signed [DW-1:0]  pending_drift_left_us,
	output logic                  signal_missed,
	output logic [SKW-1:0]        frames_skipped,
	output logic                  catchup_saturated
);

	// floor(x / 1000) as (x * RECIP_1000) >> 37, exact for x below 2^27
	localparam logic [27:0] RECIP_1000 = 28'd137438954;

	logic [TW-1:0]        nom_q;
	logic [31:0]          cnt_q;
	logic signed [DW-1:0] pend_q, corr_q;
	logic signed [31:0]   last_q;
	logic [TW-1:0]        now_q;
	logic                 conn_q;
	logic signed [31:0]   peer_q;
	logic [1:0]           stat_q;
	logic [TW-1:0]        ts_q, ft_q;
	logic                 miss_q, sat_q;
	logic [SKW-1:0]       skip_q;

	// 36x32 product in two 18-bit halves, then bit-serial restoring division
	logic [67:0] prod_q;
	logic        mhalf_q, mul_done_q;
	logic [67:0] quo_q;
	logic [18:0] rem_q;
	logic [6:0]  dcnt_q;
	logic        div_busy_q, div_done_q;
	logic [19:0] rsh;

	logic signed [DW:0]   psum, dlt;
	logic signed [DW-1:0] pnew, adj, lim, adj_mag;
	logic [26:0]          lf, lf_q;
	logic [54:0]          lf_prod;
	logic [17:0]          lfd_q;

	assign lim     = DW'(max_correction_us);
	assign lf      = 27'(max_correction_us) * 27'(frame_duration_us);
	assign lf_prod = 55'(lf_q) * 55'(RECIP_1000);

	always_comb begin
		adj_mag = DW'(lfd_q);
		if (adj_mag < lim) adj_mag = lim;
		adj = '0;
		if (pend_q > 0 && pend_q >= lim) begin
			adj = (adj_mag > pend_q) ? pend_q : adj_mag;
		end else if (pend_q < 0 && pend_q <= -lim) begin
			adj = (-adj_mag < pend_q) ? pend_q : -adj_mag;
		end
	end

	// drift delta only with a peer and from the third counted frame on
	assign dlt  = (conn_q && (cnt_q > 32'd1)) ? (DW+1)'(peer_q) - (DW+1)'(last_q) : '0;
	assign psum = (DW+1)'(pend_q) + dlt;
	assign pnew = sat40(psum);
	assign rsh  = {rem_q, quo_q[67]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q      <= '0;
			cnt_q      <= '0;
			pend_q     <= '0;
			corr_q     <= '0;
			last_q     <= '0;
			mhalf_q    <= 1'b0;
			mul_done_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			dcnt_q     <= '0;
		end else begin
			if (cmd.drift) begin
				pend_q <= pnew;
				if (conn_q) last_q <= peer_q;
			end
			if (cmd.adj) begin
				pend_q <= pend_q - adj;
				corr_q <= sat40({corr_q[DW-1], corr_q} + {adj[DW-1], adj});
			end
			mul_done_q <= cmd.mul_start && !mul_done_q && mhalf_q;
			if (cmd.mul_start && !mul_done_q) begin
				mhalf_q <= ~mhalf_q;
			end
			div_done_q <= div_busy_q && (dcnt_q == 7'd67);
			if (cmd.div_start && !div_busy_q && !div_done_q) begin
				div_busy_q <= 1'b1;
				dcnt_q     <= '0;
			end else if (div_busy_q) begin
				dcnt_q <= dcnt_q + 7'd1;
				if (dcnt_q == 7'd67) div_busy_q <= 1'b0;
			end
			if (cmd.frame) begin
				if (!format_set) nom_q <= nom_q + TW'(frame_duration_us);
				else cnt_q <= cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q  <= current_time_us;
			conn_q <= peer_connected;
			peer_q <= peer_drift_us;
			miss_q <= 1'b0;
			sat_q  <= 1'b0;
			skip_q <= '0;
			stat_q <= timer_disabled ? ST_DISABLED :
				(!primary_output_present ? ST_NO_OUT : ST_ARMED);
			ts_q   <= '0;
			lf_q   <= lf;
		end
		if (cmd.drift)
			lfd_q <= lf_prod[54:37];
		if (cmd.mul_start && !mul_done_q) begin
			if (!mhalf_q)
				prod_q <= 68'(integer_rate_us[17:0] * cnt_q);
			else
				prod_q <= prod_q + {50'(integer_rate_us[35:18] * cnt_q), 18'd0};
		end
		if (cmd.div_start && !div_busy_q && !div_done_q) begin
			quo_q <= prod_q;
			rem_q <= '0;
		end else if (div_busy_q) begin
			if (rsh >= 20'(sample_rate_hz)) begin
				rem_q <= 19'(rsh - 20'(sample_rate_hz));
				quo_q <= {quo_q[66:0], 1'b1};
			end else begin
				rem_q <= rsh[18:0];
				quo_q <= {quo_q[66:0], 1'b0};
			end
		end
		if (cmd.frame)
			ft_q <= (format_set && sample_rate_hz != '0) ? quo_q[TW-1:0] : '0;
		if (cmd.ts) begin
			ts_q <= start_time_us + nom_q + (format_set ? ft_q : '0) +
				{{(TW-DW){corr_q[DW-1]}}, corr_q};
		end
		if (cmd.skip) begin
			miss_q <= 1'b1;
			skip_q <= skip_q + SKW'(1);
		end
		if (cmd.set_sat) begin
			sat_q  <= 1'b1;
			miss_q <= 1'b1;
		end
	end

	// skip_q counts the extra frames computed after the first missed one
	assign sts.bypass   = timer_disabled | ~primary_output_present;
	assign sts.fmt      = format_set;
	assign sts.mul_done = mul_done_q;
	assign sts.div_done = div_done_q;
	assign sts.past     = ts_q < now_q;
	assign sts.limit    = skip_q >= SKW'(MAX_CATCHUP_FRAMES);

	assign status                = stat_q;
	assign next_timestamp_us     = ts_q;
	assign corrected_drift_us    = corr_q;
	assign pending_drift_left_us = pend_q;
	assign signal_missed         = miss_q;
	assign frames_skipped        = skip_q;
	assign catchup_saturated     = sat_q;

endmodule

// ===== hw/rtl/drift_corrected_frame_timer.sv =====
// Drift-corrected frame timer. Each tick request is answered by one result.
// Without a sample-rate format each frame step is a nominal advance; with
// one it costs a 36x32 multiply in two 18-bit halves and a 68-step
// bit-serial divide. Catch-up frames are computed one after another, up to
// MAX_CATCHUP_FRAMES. Disabled or no-output ticks give their result in the
// cycle after the request is taken. The next request can be taken in the
// cycle after the result is taken. The user is bound to write registers
// only while no tick is in flight; the block itself does not enforce this.
module drift_corrected_frame_timer
	import dcft_pkg::*;
#(
	parameter int MAX_CATCHUP_FRAMES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [47:0]          current_time_us,
	input  logic                 peer_connected,
	input  logic signed [31:0]   peer_drift_us,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [47:0]          next_timestamp_us,
	output logic signed [39:0]   corrected_drift_us,
	output logic signed [39:0]   pending_drift_left_us,
	output logic                 signal_missed,
	output logic [$clog2(MAX_CATCHUP_FRAMES+1)-1:0] frames_skipped,
	output logic                 catchup_saturated
);

	localparam int SKW = $clog2(MAX_CATCHUP_FRAMES + 1);

	logic        dis_q, prim_q, fmt_q;
	logic [16:0] frame_q;
	logic [18:0] rate_q;
	logic [35:0] irate_q;
	logic [9:0]  maxc_q;
	logic [47:0] start_q;
	cmd_t        cmd;
	sts_t        sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dis_q   <= 1'b0;
			prim_q  <= 1'b1;
			fmt_q   <= 1'b0;
			frame_q <= 17'd1000;
			rate_q  <= 19'd48000;
			irate_q <= 36'd48000000;
			maxc_q  <= 10'd1;
			start_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DISABLED: dis_q   <= cfg_data[0];
				CFG_PRIMARY:  prim_q  <= cfg_data[0];
				CFG_FORMAT:   fmt_q   <= cfg_data[0];
				CFG_FRAME:    frame_q <= cfg_data[16:0];
				CFG_RATE:     rate_q  <= cfg_data[18:0];
				CFG_IRATE:    irate_q <= cfg_data[35:0];
				CFG_MAXCORR:  maxc_q  <= cfg_data[9:0];
				CFG_START:    start_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	dcft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dcft_dp #(
		.MAX_CATCHUP_FRAMES (MAX_CATCHUP_FRAMES),
		.SKW                (SKW)
	) u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.sts                    (sts),
		.timer_disabled         (dis_q),
		.primary_output_present (prim_q),
		.format_set             (fmt_q),
		.frame_duration_us      (frame_q),
		.sample_rate_hz         (rate_q),
		.integer_rate_us        (irate_q),
		.max_correction_us      (maxc_q),
		.start_time_us          (start_q),
		.current_time_us        (current_time_us),
		.peer_connected         (peer_connected),
		.peer_drift_us          (peer_drift_us),
		.status                 (status),
		.next_timestamp_us      (next_timestamp_us),
		.corrected_drift_us     (corrected_drift_us),
		.pending_drift_left_us  (pending_drift_left_us),
		.signal_missed          (signal_missed),
		.frames_skipped         (frames_skipped),
		.catchup_saturated      (catchup_saturated)
	);

endmodule
